// ----- design/utv_pkg.sv -----
// Package with the shared types, constants and helpers of the UTF-8 target validator.
package utv_pkg;

  localparam int ByteW = 8;
  localparam int CpW   = 21;

  localparam logic [ByteW-1:0] BYTE_NUL      = 8'h00;
  localparam logic [ByteW-1:0] BYTE_DEL      = 8'h7f;
  localparam logic [ByteW-1:0] BYTE_SPACE    = 8'h20;
  localparam logic [ByteW-1:0] LEAD2_LO      = 8'hc2;
  localparam logic [ByteW-1:0] LEAD2_HI      = 8'hdf;
  localparam logic [ByteW-1:0] LEAD3_LO      = 8'he0;
  localparam logic [ByteW-1:0] LEAD3_HI      = 8'hef;
  localparam logic [ByteW-1:0] LEAD4_LO      = 8'hf0;
  localparam logic [ByteW-1:0] LEAD4_HI      = 8'hf4;

  localparam logic [CpW-1:0] CP_MAX          = 21'h10ffff;
  localparam logic [CpW-1:0] SURR_LO         = 21'h00d800;
  localparam logic [CpW-1:0] SURR_HI         = 21'h00dfff;

  // Length class of the sequence in flight.
  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_TWO  = 2'd1;
  localparam logic [1:0] LEN_THREE = 2'd2;
  localparam logic [1:0] LEN_FOUR = 2'd3;

  typedef struct packed {
    logic [1:0]     pending;
    logic [CpW-1:0] partial;
    logic [1:0]     len_class;
    logic           err;
  } state_t;

  typedef struct packed {
    logic           end_of_target;
    logic           target_valid;
    logic           char_complete;
    logic [CpW-1:0] code_point;
  } result_t;

  // Smallest value that is not an overlong form for each length class.
  function automatic logic [CpW-1:0] min_value(input logic [1:0] len_class);
    logic [CpW-1:0] v;
    unique case (len_class)
      LEN_NONE:  v = 21'h000000;
      LEN_TWO:   v = 21'h000080;
      LEN_THREE: v = 21'h000800;
      LEN_FOUR:  v = 21'h010000;
      default:   v = 21'h000000;
    endcase
    return v;
  endfunction

endpackage

// ----- design/utv_step.sv -----
// Combinational decode of one byte against the current sequence state.
module utv_step (
  input  logic [utv_pkg::ByteW-1:0] byte_i,
  input  utv_pkg::state_t           state_i,
  output utv_pkg::state_t           state_o,
  output utv_pkg::result_t          result_o
);
  import utv_pkg::*;

  logic [CpW-1:0] shifted;
  logic [1:0]     pend_dec;
  logic           is_cont;
  logic           range_bad;

  assign shifted   = {state_i.partial[CpW-7:0], byte_i[5:0]};
  assign pend_dec  = state_i.pending - 2'd1;
  assign is_cont   = (byte_i[7:6] == 2'b10);
  assign range_bad = (shifted < min_value(state_i.len_class)) || (shifted > CP_MAX) ||
                     ((shifted >= SURR_LO) && (shifted <= SURR_HI));

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (byte_i == BYTE_NUL) begin
      result_o.end_of_target = 1'b1;
      result_o.target_valid  = !state_i.err && (state_i.pending == 2'd0);
      state_o                = '0;
    end else if (state_i.err) begin
      state_o = state_i;
    end else if (state_i.pending != 2'd0) begin
      if (!is_cont) begin
        state_o     = '0;
        state_o.err = 1'b1;
      end else if (pend_dec == 2'd0) begin
        state_o = '0;
        if (range_bad) begin
          state_o.err = 1'b1;
        end else begin
          result_o.target_valid  = 1'b1;
          result_o.char_complete = 1'b1;
          result_o.code_point    = shifted;
        end
      end else begin
        state_o.partial       = shifted;
        state_o.pending       = pend_dec;
        result_o.target_valid = 1'b1;
      end
    end else if (!byte_i[7]) begin
      if ((byte_i < BYTE_SPACE) || (byte_i == BYTE_DEL)) begin
        state_o.err = 1'b1;
      end else begin
        result_o.target_valid  = 1'b1;
        result_o.char_complete = 1'b1;
        result_o.code_point    = {{(CpW-ByteW){1'b0}}, byte_i};
      end
    end else if ((byte_i >= LEAD2_LO) && (byte_i <= LEAD2_HI)) begin
      state_o.partial       = {{(CpW-5){1'b0}}, byte_i[4:0]};
      state_o.pending       = 2'd1;
      state_o.len_class     = LEN_TWO;
      result_o.target_valid = 1'b1;
    end else if ((byte_i >= LEAD3_LO) && (byte_i <= LEAD3_HI)) begin
      state_o.partial       = {{(CpW-4){1'b0}}, byte_i[3:0]};
      state_o.pending       = 2'd2;
      state_o.len_class     = LEN_THREE;
      result_o.target_valid = 1'b1;
    end else if ((byte_i >= LEAD4_LO) && (byte_i <= LEAD4_HI)) begin
      state_o.partial       = {{(CpW-3){1'b0}}, byte_i[2:0]};
      state_o.pending       = 2'd3;
      state_o.len_class     = LEN_FOUR;
      result_o.target_valid = 1'b1;
    end else begin
      state_o     = '0;
      state_o.err = 1'b1;
    end
  end

endmodule

// ----- design/utf8_target_validator_top.sv -----
// Top level of the streaming strict UTF-8 validator for NUL-terminated strings.
// An accepted byte moves from the input stage into the result register once that
// register is free. Throughput: one byte per cycle while out_stall is low; the
// decode of a byte against the sequence state is one short combinational step
// between the input and result registers.
// Reset (rst_n low, synchronous) empties both stages and clears the sequence state.
module utf8_target_validator_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [utv_pkg::ByteW-1:0] in_byte_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_end_of_target,
  output logic                      out_target_valid,
  output logic                      out_char_complete,
  output logic [utv_pkg::CpW-1:0]   out_code_point
);
  import utv_pkg::*;

  // Input stage: holds one request. It can refill while a finished result
  // still waits in the output register, so the two sides are decoupled.
  logic             s1_vld_r, s1_vld_nxt;
  logic [ByteW-1:0] s1_byte_r, s1_byte_nxt;

  // Sequence state, advanced when a request moves from the input stage
  // into the result register.
  state_t           st_r, st_nxt;
  state_t           st_step;
  result_t          res_step;

  // Result register.
  logic             out_vld_r, out_vld_nxt;
  result_t          out_res_r, out_res_nxt;

  logic             out_free;
  logic             in_take;
  logic             s1_move;

  // The result register can take a new entry when it is empty or being drained.
  assign out_free = !out_vld_r || !out_stall;
  assign s1_move  = s1_vld_r && out_free;
  // The input stage is full and cannot pass its request on: hold the sender off.
  assign in_stall = s1_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  utv_step u_step (
    .byte_i   (s1_byte_r),
    .state_i  (st_r),
    .state_o  (st_step),
    .result_o (res_step)
  );

  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    s1_byte_nxt = s1_byte_r;
    if (in_take) begin
      s1_vld_nxt  = 1'b1;
      s1_byte_nxt = in_byte_value;
    end else if (s1_move) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    st_nxt      = st_r;
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (s1_move) begin
      st_nxt      = st_step;
      out_vld_nxt = 1'b1;
      out_res_nxt = res_step;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      st_r      <= st_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_end_of_target = out_res_r.end_of_target;
  assign out_target_valid  = out_res_r.target_valid;
  assign out_char_complete = out_res_r.char_complete;
  assign out_code_point    = out_res_r.code_point;

  // A terminator always returns the sequence state to its reset value.
  a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && (s1_byte_r == BYTE_NUL)) |=> (st_r == '0))
    else $error("sequence state not cleared after terminator");

  // An error stays set until a terminator passes.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && st_r.err && (s1_byte_r != BYTE_NUL)) |=> st_r.err)
    else $error("error flag dropped before terminator");

  // A completed character is never reported on a terminator or in an invalid string.
  a_char_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.char_complete) |->
      (out_res_r.target_valid && !out_res_r.end_of_target))
    else $error("character completion on invalid string or terminator");

  // No code point is reported without a completed character.
  a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_res_r.char_complete) |-> (out_res_r.code_point == '0))
    else $error("code point set without completed character");

endmodule
